@@ rtl/nearest_centroid_index_packer_unit_macros.svh @@
// assertion macros for the nearest centroid index packer checker
// needs clk and arst_n in the scope of each use
`ifndef NEAREST_CENTROID_INDEX_PACKER_UNIT_MACROS_SVH
`define NEAREST_CENTROID_INDEX_PACKER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define NCIP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ncip check failed");

// next-cycle implication, off during reset
`define NCIP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ncip check failed");

// next-cycle implication checked at every edge, reset included
`define NCIP_ASSERT_ALWAYS(label, ante, cons) \
	label: assert property (@(posedge clk) (ante) |=> (cons)) \
		else $error("ncip check failed");

`endif

@@ rtl/ncip_pkg.sv @@
// shared types, constants and fp16 conversion for the index packer
// no dependencies
`default_nettype none

package ncip_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int SMALL_BOOK = 16;
	localparam int FIX_W = 43;
	localparam int CMDQ_DEPTH = 4;
	localparam int RESQ_DEPTH = 4;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_ELEM = 2'd1;
	localparam logic [1:0] KIND_NORM = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] slot;
		logic [15:0] value;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic last;
	} res_t;

	typedef struct packed {
		logic push;
		res_t data;
	} res_wr_t;

	function automatic logic signed [FIX_W-1:0] half_to_fixed(input logic [15:0] h);
		logic [4:0] e;
		logic [9:0] m;
		logic [FIX_W-1:0] mag;
		e = h[14:10];
		m = h[9:0];
		if (e == 5'd0) begin
			mag = FIX_W'(m);
		end else begin
			mag = FIX_W'({1'b1, m}) << (e - 5'd1);
		end
		half_to_fixed = h[15] ? -mag : mag;
	endfunction

endpackage

`default_nettype wire

@@ rtl/nearest_centroid_index_packer_unit.sv @@
// top level of the nearest centroid index packer: mode register and the three parts
// depends on ncip_pkg, ncip_front, ncip_engine, ncip_res_queue
//
// channel   handshake        payload
// input     push / full      item   (kind, slot, value)
// result    empty / pop      result (out_byte, last)
// config    cfg_we           cfg_data (wide_book)
//
// an element reads 16 (mode 0) or 256 (mode 1) codebook entries on the
// single memory port, then drains the search pipeline before it finishes
// loads write when taken, norms add a second byte; ignored items skip the engine
// reset clears queues, mode and pending nibble; the codebook is unset until loaded
// input and result queues of 4 let either side stall on its own
`default_nettype none

module nearest_centroid_index_packer_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input ncip_pkg::item_t item,
	output logic empty,
	input wire logic pop,
	output ncip_pkg::res_t result,
	input wire logic cfg_we,
	input wire logic cfg_data
);

	logic wide_book_q;
	logic cmd_valid;
	ncip_pkg::item_t cmd;
	logic cmd_pop;
	logic res_room;
	ncip_pkg::res_wr_t res_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_book_q <= 1'b0;
		end else if (cfg_we) begin
			wide_book_q <= cfg_data;
		end
	end

	ncip_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	ncip_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.wide_book(wide_book_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.res_room(res_room),
		.res_wr(res_wr)
	);

	ncip_res_queue u_res_queue (
		.clk(clk),
		.arst_n(arst_n),
		.res_wr(res_wr),
		.room(res_room),
		.empty(empty),
		.result(result),
		.pop(pop)
	);

endmodule

`default_nettype wire

@@ rtl/ncip_front.sv @@
// input side: takes items, drops those with no effect, queues the rest
// depends on ncip_pkg
`default_nettype none

module ncip_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input ncip_pkg::item_t item,
	output logic cmd_valid,
	output ncip_pkg::item_t cmd,
	input wire logic cmd_pop
);

	localparam int PTR_W = $clog2(ncip_pkg::CMDQ_DEPTH);
	localparam int CNT_W = $clog2(ncip_pkg::CMDQ_DEPTH + 1);

	ncip_pkg::item_t entry_q [ncip_pkg::CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic keep;
	logic enq;
	logic deq;

	always_comb begin
		unique case (item.kind)
			ncip_pkg::KIND_LOAD: keep = ({1'b0, item.slot} < 9'(ncip_pkg::TABLE_DEPTH));
			ncip_pkg::KIND_ELEM: keep = 1'b1;
			ncip_pkg::KIND_NORM: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign full = (count_q == CNT_W'(ncip_pkg::CMDQ_DEPTH));
	assign enq = push && !full && keep;
	assign cmd_valid = (count_q != '0);
	assign deq = cmd_pop && cmd_valid;
	assign cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (enq && !deq) begin
				count_q <= count_q + CNT_W'(1);
			end else if (deq && !enq) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/ncip_engine.sv @@
// back side: codebook memory, nearest-entry search, nibble packing, norm bytes
// depends on ncip_pkg
`default_nettype none

module ncip_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wide_book,
	input wire logic cmd_valid,
	input ncip_pkg::item_t cmd,
	output logic cmd_pop,
	input wire logic res_room,
	output ncip_pkg::res_wr_t res_wr
);

	localparam int AW = ncip_pkg::ADDR_W;
	localparam int FW = ncip_pkg::FIX_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_NORM = 2'd3;

	logic [15:0] mem [ncip_pkg::TABLE_DEPTH];

	logic [1:0] state_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] last_k_q;
	logic mode_q;
	logic signed [FW-1:0] xfix_q;
	logic [7:0] hi_q;
	logic [3:0] held_q;
	logic waiting_q;

	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [15:0] rd_s1;
	logic v1_s1;
	logic v2_s2;
	logic v3_s3;
	logic [AW-1:0] idx_s1;
	logic [AW-1:0] idx_s2;
	logic [AW-1:0] idx_s3;
	logic signed [FW-1:0] cfix_s2;
	logic [FW:0] dist_s3;
	logic [FW:0] best_q;
	logic [AW-1:0] best_idx_q;

	logic start;
	logic searching;
	logic finish;
	logic signed [FW:0] d_pos;
	logic signed [FW:0] d_neg;

	assign start = (state_q == ST_IDLE) && cmd_valid && res_room;
	assign cmd_pop = start;
	assign searching = (state_q == ST_SEARCH);
	assign finish = (state_q == ST_DRAIN) && !v1_s1 && !v2_s2 && !v3_s3;
	assign mem_we = start && (cmd.kind == ncip_pkg::KIND_LOAD);
	assign mem_addr = searching ? k_q : cmd.slot[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= cmd.value;
		end
		rd_s1 <= mem[mem_addr];
	end

	assign d_pos = {xfix_q[FW-1], xfix_q} - {cfix_s2[FW-1], cfix_s2};
	assign d_neg = {cfix_s2[FW-1], cfix_s2} - {xfix_q[FW-1], xfix_q};

	always_ff @(posedge clk) begin
		idx_s1 <= k_q;
		cfix_s2 <= ncip_pkg::half_to_fixed(rd_s1);
		idx_s2 <= idx_s1;
		dist_s3 <= d_pos[FW] ? d_neg : d_pos;
		idx_s3 <= idx_s2;
		if (v3_s3 && (idx_s3 == '0 || dist_s3 < best_q)) begin
			best_q <= dist_s3;
			best_idx_q <= idx_s3;
		end
		if (start) begin
			xfix_q <= ncip_pkg::half_to_fixed(cmd.value);
			hi_q <= cmd.value[15:8];
			mode_q <= wide_book;
			last_k_q <= wide_book ? AW'(ncip_pkg::TABLE_DEPTH - 1)
				: AW'(ncip_pkg::SMALL_BOOK - 1);
		end
	end

	always_comb begin
		res_wr = '0;
		if (start && cmd.kind == ncip_pkg::KIND_NORM) begin
			res_wr.push = 1'b1;
			res_wr.data.out_byte = cmd.value[7:0];
		end else if (state_q == ST_NORM) begin
			res_wr.push = 1'b1;
			res_wr.data.out_byte = hi_q;
			res_wr.data.last = 1'b1;
		end else if (finish) begin
			if (mode_q) begin
				res_wr.push = 1'b1;
				res_wr.data.out_byte = 8'(best_idx_q);
			end else if (waiting_q) begin
				res_wr.push = 1'b1;
				res_wr.data.out_byte = {held_q, best_idx_q[3:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			held_q <= '0;
			waiting_q <= 1'b0;
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			v1_s1 <= searching;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						priority case (cmd.kind)
							ncip_pkg::KIND_ELEM: begin
								k_q <= '0;
								state_q <= ST_SEARCH;
							end
							ncip_pkg::KIND_NORM: begin
								held_q <= '0;
								waiting_q <= 1'b0;
								state_q <= ST_NORM;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SEARCH: begin
					k_q <= k_q + AW'(1);
					if (k_q == last_k_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						if (mode_q || waiting_q) begin
							held_q <= '0;
							waiting_q <= 1'b0;
						end else begin
							held_q <= best_idx_q[3:0];
							waiting_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_NORM: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/ncip_res_queue.sv @@
// result queue between the engine and the output ports
// depends on ncip_pkg
`default_nettype none

module ncip_res_queue (
	input wire logic clk,
	input wire logic arst_n,
	input ncip_pkg::res_wr_t res_wr,
	output logic room,
	output logic empty,
	output ncip_pkg::res_t result,
	input wire logic pop
);

	localparam int PTR_W = $clog2(ncip_pkg::RESQ_DEPTH);
	localparam int CNT_W = $clog2(ncip_pkg::RESQ_DEPTH + 1);

	ncip_pkg::res_t entry_q [ncip_pkg::RESQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic deq;

	assign empty = (count_q == '0);
	assign room = (count_q <= CNT_W'(ncip_pkg::RESQ_DEPTH - 2));
	assign deq = pop && !empty;
	assign result = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_wr.push) begin
			entry_q[wr_ptr_q] <= res_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (res_wr.push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (res_wr.push && !deq) begin
				count_q <= count_q + CNT_W'(1);
			end else if (deq && !res_wr.push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/ncip_checker.sv @@
// port-level checks for the nearest centroid index packer, bound to the top level
// depends on ncip_pkg and nearest_centroid_index_packer_unit_macros.svh
`default_nettype none
`include "nearest_centroid_index_packer_unit_macros.svh"

module ncip_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input ncip_pkg::res_t result
);

	// waiting item holds until taken
	`NCIP_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result))

	// queues come out of reset empty
	`NCIP_ASSERT_ALWAYS(a_reset, !arst_n, empty && !full)

	// a vector's last byte is never directly followed by another last byte
	`NCIP_ASSERT_NEXT(a_last_alone, !empty && pop && result.last, empty || !result.last)

endmodule

bind nearest_centroid_index_packer_unit ncip_checker u_ncip_checker (.*);

`default_nettype wire
